// ===== design/vcrt_pkg.sv =====
// ---------------------------------------------------------------------------
// vcrt_pkg
// Shared types, codes and default settings of the video chunk tracker.
// ---------------------------------------------------------------------------
package vcrt_pkg;

	// Default geometry and header size.
	localparam int unsigned DEF_MAX_WIDTH    = 400;
	localparam int unsigned DEF_MAX_HEIGHT   = 240;
	localparam int unsigned DEF_HEADER_BYTES = 16;
	localparam int unsigned DEF_PIXEL_BYTES  = 2;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_MAGIC   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_VERSION = CFG_IDX_W'(1);

	// Result queue depth; one item may push two results.
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		VERDICT_ACC    = 2'd0,
		VERDICT_BAD    = 2'd1,
		VERDICT_LATE   = 2'd2,
		VERDICT_CLOSED = 2'd3
	} verdict_t;

	// Push request from the tracker into the result queue.
	typedef struct packed {
		logic valid; // an item was processed, the final result is pushed
		logic pair;  // a frame-close result goes in ahead of the final one
	} push_t;

endpackage

// ===== design/vcrt_hdr_check.sv =====
// ---------------------------------------------------------------------------
// vcrt_hdr_check
// Header validation: length, magic, version, geometry, buffer and frame bounds.
// ---------------------------------------------------------------------------
module vcrt_hdr_check import vcrt_pkg::*; #(
	parameter int unsigned MAX_WIDTH    = DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT   = DEF_MAX_HEIGHT,
	parameter int unsigned HEADER_BYTES = DEF_HEADER_BYTES,
	parameter int unsigned PIXEL_BYTES  = DEF_PIXEL_BYTES
) (
	input  logic [15:0] datagram_length,
	input  logic [15:0] magic,
	input  logic [7:0]  version,
	input  logic [31:0] byte_offset,
	input  logic [15:0] frame_width,
	input  logic [15:0] frame_height,
	input  logic [15:0] expected_magic,
	input  logic [7:0]  expected_version,
	output logic        bad,
	output logic [15:0] payload_len,
	output logic [31:0] frame_bytes
);

	localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
	localparam int unsigned HW   = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned MAXB = MAX_WIDTH * MAX_HEIGHT * PIXEL_BYTES;

	logic [WW+HW-1:0] area;
	logic [32:0]      end_pos;

	// Geometry out of range makes the header bad, so the truncated product
	// only matters when it is exact.
	assign area        = (WW+HW)'(frame_width[WW-1:0]) * (WW+HW)'(frame_height[HW-1:0]);
	assign frame_bytes = 32'(area) * 32'(PIXEL_BYTES);
	assign payload_len = datagram_length - 16'(HEADER_BYTES);
	assign end_pos     = {1'b0, byte_offset} + 33'(payload_len);

	always_comb begin
		bad = 1'b0;
		if (datagram_length <= 16'(HEADER_BYTES)) bad = 1'b1;
		if (magic != expected_magic) bad = 1'b1;
		if (version != expected_version) bad = 1'b1;
		if (frame_width == 16'd0 || frame_width[0]) bad = 1'b1;
		if (frame_height == 16'd0) bad = 1'b1;
		if (frame_width > 16'(MAX_WIDTH)) bad = 1'b1;
		if (frame_height > 16'(MAX_HEIGHT)) bad = 1'b1;
		if (byte_offset > 32'(MAXB)) bad = 1'b1;
		if (end_pos > 33'(MAXB)) bad = 1'b1;
		if (end_pos > {1'b0, frame_bytes}) bad = 1'b1;
	end

endmodule

// ===== design/vcrt_frame_tracker.sv =====
// ---------------------------------------------------------------------------
// vcrt_frame_tracker
// Frame state, late-chunk filter, counters and result formatting.
// ---------------------------------------------------------------------------
module vcrt_frame_tracker import vcrt_pkg::*; #(
	parameter int unsigned MAX_WIDTH   = DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT  = DEF_MAX_HEIGHT,
	parameter int unsigned PIXEL_BYTES = DEF_PIXEL_BYTES,
	parameter int unsigned RW          = 186
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  logic          bad,
	input  logic          last_flag,
	input  logic [31:0]   sequence_req,
	input  logic [31:0]   byte_offset,
	input  logic [15:0]   frame_width,
	input  logic [15:0]   frame_height,
	input  logic [15:0]   payload_len,
	input  logic [31:0]   frame_bytes,
	output push_t         push,
	output logic [RW-1:0] close_res,
	output logic [RW-1:0] final_res
);

	localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
	localparam int unsigned HW   = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned MAXB = MAX_WIDTH * MAX_HEIGHT * PIXEL_BYTES;
	localparam int unsigned OW   = $clog2(MAXB + 1);
	localparam int unsigned TDW  = RW - 3;

	logic          seen_q, prog_q;
	logic [31:0]   seq_q, bytes_q, want_q;
	logic [WW-1:0] cw_q;
	logic [HW-1:0] ch_q;
	logic [31:0]   fin_q, whl_q, rej_q, lat_q;

	logic          late, newf, acc, closing, close0, whole0, whole1;
	logic [31:0]   seq_diff, bytes_n, want_c;
	logic [31:0]   fin_a, whl_a, fin_b, whl_b, rej_n, lat_n;
	logic [WW-1:0] cw_c;
	logic [HW-1:0] ch_c;
	verdict_t      verdict;
	logic [OW-1:0] woff, wlen;

	assign seq_diff = sequence_req - seq_q;
	assign late     = !bad && seen_q && (seq_diff[31] || (sequence_req == seq_q && !prog_q));
	assign acc      = !bad && !late;
	assign newf     = acc && (sequence_req != seq_q || !seen_q);
	assign close0   = newf && prog_q;
	assign whole0   = (bytes_q == want_q);
	assign closing  = acc && last_flag;

	assign bytes_n = (newf ? 32'd0 : bytes_q) + 32'(payload_len);
	assign want_c  = newf ? frame_bytes : want_q;
	assign cw_c    = newf ? frame_width[WW-1:0] : cw_q;
	assign ch_c    = newf ? frame_height[HW-1:0] : ch_q;
	assign whole1  = (bytes_n == want_c);

	// Counters as seen by the close report, then by the final result.
	assign fin_a = fin_q + 32'(close0);
	assign whl_a = whl_q + 32'(close0 && whole0);
	assign fin_b = fin_a + 32'(closing);
	assign whl_b = whl_a + 32'(closing && whole1);
	assign rej_n = rej_q + 32'(bad);
	assign lat_n = lat_q + 32'(late);

	always_comb begin
		if (bad) begin
			verdict = VERDICT_BAD;
		end else if (late) begin
			verdict = VERDICT_LATE;
		end else begin
			verdict = VERDICT_ACC;
		end
	end

	assign woff = acc ? byte_offset[OW-1:0] : '0;
	assign wlen = acc ? OW'(payload_len) : '0;

	assign close_res = {1'b0, VERDICT_CLOSED,
		TDW'({lat_q, rej_q, whl_a, fin_a, whole0, ch_q, cw_q, 1'b1,
			{OW{1'b0}}, {OW{1'b0}}})};

	assign final_res = {1'b1, verdict,
		TDW'({lat_n, rej_n, whl_b, fin_b, closing && whole1,
			closing ? ch_c : {HW{1'b0}}, closing ? cw_c : {WW{1'b0}}, closing,
			wlen, woff})};

	assign push.valid = fire;
	assign push.pair  = fire && close0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= 1'b0;
			prog_q  <= 1'b0;
			seq_q   <= '0;
			bytes_q <= '0;
			want_q  <= '0;
			cw_q    <= '0;
			ch_q    <= '0;
			fin_q   <= '0;
			whl_q   <= '0;
			rej_q   <= '0;
			lat_q   <= '0;
		end else if (fire) begin
			fin_q <= fin_b;
			whl_q <= whl_b;
			rej_q <= rej_n;
			lat_q <= lat_n;
			if (acc) begin
				bytes_q <= bytes_n;
				prog_q  <= !last_flag;
			end
			if (newf) begin
				seen_q <= 1'b1;
				seq_q  <= sequence_req;
				want_q <= frame_bytes;
				cw_q   <= cw_c;
				ch_q   <= ch_c;
			end
		end
	end

endmodule

// ===== design/vcrt_out_queue.sv =====
// ---------------------------------------------------------------------------
// vcrt_out_queue
// Small result queue; takes one or two results a cycle, gives out one while out_ready is high.
// ---------------------------------------------------------------------------
module vcrt_out_queue import vcrt_pkg::*; #(
	parameter int unsigned RW = 186
) (
	input  logic          clk,
	input  logic          arst_n,
	input  push_t         push,
	input  logic [RW-1:0] close_res,
	input  logic [RW-1:0] final_res,
	output logic          room,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [RW-1:0] out_res
);

	logic [RW-1:0]     mem_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q, wp_1;
	logic [QCNT_W-1:0] cnt_q;
	logic              pop;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign room      = (cnt_q <= QCNT_W'(QDEPTH - 2));
	assign out_res   = mem_q[rp_q];
	assign wp_1      = wp_q + QPTR_W'(1);

	always_ff @(posedge clk) begin
		if (push.valid) begin
			if (push.pair) begin
				mem_q[wp_q] <= close_res;
				mem_q[wp_1] <= final_res;
			end else begin
				mem_q[wp_q] <= final_res;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + QPTR_W'(push.valid) + QPTR_W'(push.pair);
			rp_q  <= rp_q + QPTR_W'(pop);
			cnt_q <= cnt_q + QCNT_W'(push.valid) + QCNT_W'(push.pair) - QCNT_W'(pop);
		end
	end

endmodule

// ===== design/video_chunk_reassembly_tracker_top.sv =====
// ---------------------------------------------------------------------------
// video_chunk_reassembly_tracker_top
// Checks parsed datagram headers, tracks frame reassembly and reports writes.
// A header is held in the input register, then its results are written into the
// result queue. Throughput: one header per cycle while the queue has room for two
// results; a header that closes an open frame on a newer sequence gives two results.
// Reset: arst_n clears the frame state, all counters and both registers to 0.
// ---------------------------------------------------------------------------
module video_chunk_reassembly_tracker_top import vcrt_pkg::*; #(
	parameter int unsigned MAX_WIDTH    = DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT   = DEF_MAX_HEIGHT,
	parameter int unsigned HEADER_BYTES = DEF_HEADER_BYTES,
	parameter int unsigned PIXEL_BYTES  = DEF_PIXEL_BYTES,
	// Derived sizes of the result fields.
	localparam int unsigned WW   = $clog2(MAX_WIDTH + 1),
	localparam int unsigned HW   = $clog2(MAX_HEIGHT + 1),
	localparam int unsigned MAXB = MAX_WIDTH * MAX_HEIGHT * PIXEL_BYTES,
	localparam int unsigned OW   = $clog2(MAXB + 1),
	localparam int unsigned ODW  = 2 * OW + WW + HW + 2 + 128,
	localparam int unsigned TDW  = ((ODW + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration write channel.
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	// Header stream.
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// tdata from bit 0: datagram_length(16), magic(16), version(8),
	// sequence_req(32), byte_offset(32), frame_width(16), frame_height(16)
	input  logic [135:0]         s_axis_tdata,
	input  logic                 s_axis_tlast,  // last_flag
	// Result stream.
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// tdata from bit 0: write_offset, write_length, frame_done, done_width,
	// done_height, done_whole, frames_finished(32), frames_whole(32),
	// bad_count(32), late_count(32), zero fill
	output logic [TDW-1:0]       m_axis_tdata,
	output logic [1:0]           m_axis_tuser,  // verdict
	output logic                 m_axis_tlast   // last_result
);

	localparam int unsigned RW = TDW + 3;

	// Configuration registers. Writes must come only while the block is idle; the block
	// does not enforce this. The channel is always ready and a write takes effect at once.
	logic [15:0] magic_q;
	logic [7:0]  version_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q   <= '0;
			version_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MAGIC:   magic_q   <= cfg_data;
				REG_VERSION: version_q <= cfg_data[7:0];
				default:     ;
			endcase
		end
	end

	// Input register. The held header is processed as soon as the result
	// queue has room for two results, and a new header is taken in the same
	// cycle, so while the output takes every result, the input side never waits on a single-result stream.
	logic          valid_s1;
	logic [135:0]  data_s1;
	logic          last_s1;
	logic          fire, room;

	assign fire          = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// Header checks run on the registered header.
	logic        bad;
	logic [15:0] payload_len;
	logic [31:0] frame_bytes;

	vcrt_hdr_check #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_HEIGHT   (MAX_HEIGHT),
		.HEADER_BYTES (HEADER_BYTES),
		.PIXEL_BYTES  (PIXEL_BYTES)
	) u_check (
		.datagram_length  (data_s1[15:0]),
		.magic            (data_s1[31:16]),
		.version          (data_s1[39:32]),
		.byte_offset      (data_s1[103:72]),
		.frame_width      (data_s1[119:104]),
		.frame_height     (data_s1[135:120]),
		.expected_magic   (magic_q),
		.expected_version (version_q),
		.bad              (bad),
		.payload_len      (payload_len),
		.frame_bytes      (frame_bytes)
	);

	// Frame tracking: sequence filter, frame close and counter updates. It
	// produces the optional close report and the final result of the header.
	push_t         push;
	logic [RW-1:0] close_res, final_res, out_res;

	vcrt_frame_tracker #(
		.MAX_WIDTH   (MAX_WIDTH),
		.MAX_HEIGHT  (MAX_HEIGHT),
		.PIXEL_BYTES (PIXEL_BYTES),
		.RW          (RW)
	) u_tracker (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.bad          (bad),
		.last_flag    (last_s1),
		.sequence_req (data_s1[71:40]),
		.byte_offset  (data_s1[103:72]),
		.frame_width  (data_s1[119:104]),
		.frame_height (data_s1[135:120]),
		.payload_len  (payload_len),
		.frame_bytes  (frame_bytes),
		.push         (push),
		.close_res    (close_res),
		.final_res    (final_res)
	);

	// Result queue decouples the output handshake from processing. Each
	// entry holds last_result, verdict and the packed tdata.
	vcrt_out_queue #(
		.RW (RW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.close_res (close_res),
		.final_res (final_res),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = out_res[TDW-1:0];
	assign m_axis_tuser = out_res[TDW+1:TDW];
	assign m_axis_tlast = out_res[TDW+2];

endmodule

// ===== tb/video_chunk_reassembly_tracker_top_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// video_chunk_reassembly_tracker_top_test
// Drives parsed datagram headers into the tracker and scores every result
// against a cycle-free model of the frame tracker kept in this bench. It runs
// directed header checks and frame lifecycle cases, then random frame
// traffic under several magic and version settings, with random idle gaps on
// both stream sides outside one steady run.
// ---------------------------------------------------------------------------
module video_chunk_reassembly_tracker_top_test;
	import vcrt_pkg::*;

	// Geometry of the default build, and the layout of the result word.
	localparam int unsigned MAXW      = DEF_MAX_WIDTH;
	localparam int unsigned MAXH      = DEF_MAX_HEIGHT;
	localparam int unsigned HDR_BYTES = DEF_HEADER_BYTES;
	localparam int unsigned PIX_BYTES = DEF_PIXEL_BYTES;
	localparam int unsigned BUF_BYTES = MAXW * MAXH * PIX_BYTES;
	localparam int unsigned OFF_W     = $clog2(BUF_BYTES + 1);
	localparam int unsigned DW_W      = $clog2(MAXW + 1);
	localparam int unsigned DH_W      = $clog2(MAXH + 1);
	localparam int unsigned RES_W     = ((2 * OFF_W + DW_W + DH_W + 2 + 128 + 7) / 8) * 8;
	localparam int unsigned P_WLEN    = OFF_W;
	localparam int unsigned P_DONE    = 2 * OFF_W;
	localparam int unsigned P_DW      = P_DONE + 1;
	localparam int unsigned P_DH      = P_DW + DW_W;
	localparam int unsigned P_WHOLE   = P_DH + DH_W;
	localparam int unsigned P_FIN     = P_WHOLE + 1;
	localparam int unsigned P_WHC     = P_FIN + 32;
	localparam int unsigned P_BAD     = P_WHC + 32;
	localparam int unsigned P_LATE    = P_BAD + 32;

	// One parsed datagram header as it enters the block.
	typedef struct {
		logic [15:0] length;
		logic [15:0] magic;
		logic [7:0]  version;
		logic        last;
		logic [31:0] seq;
		logic [31:0] offset;
		logic [15:0] width;
		logic [15:0] height;
	} header_t;

	// One result as the tracker should report it.
	typedef struct {
		verdict_t          verdict;
		logic [OFF_W-1:0]  wr_offset;
		logic [OFF_W-1:0]  wr_length;
		logic              done;
		logic [DW_W-1:0]   done_w;
		logic [DH_W-1:0]   done_h;
		logic              done_whole;
		logic [31:0]       finished;
		logic [31:0]       whole_frames;
		logic [31:0]       rejected;
		logic [31:0]       stragglers;
		logic              last;
	} report_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0]          cfg_data;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	// From bit 0: datagram_length, magic, version, sequence_req, byte_offset,
	// frame_width, frame_height.
	logic [135:0]         s_axis_tdata;
	logic                 s_axis_tlast;   // last_flag
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	// From bit 0: write_offset, write_length, frame_done, done_width,
	// done_height, done_whole, frames_finished, frames_whole, bad_count,
	// late_count, zero fill.
	logic [RES_W-1:0]     m_axis_tdata;
	logic [1:0]           m_axis_tuser;   // verdict
	logic                 m_axis_tlast;   // last_result

	video_chunk_reassembly_tracker_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Bench copy of the registers and of the tracker state. All of it starts
	// at zero, as the block does after reset.
	logic [15:0] cfg_magic    = '0;
	logic [7:0]  cfg_version  = '0;
	logic        trk_seen     = 1'b0;
	logic        trk_open     = 1'b0;
	logic [31:0] trk_seq      = '0;
	logic [8:0]  trk_w        = '0;
	logic [7:0]  trk_h        = '0;
	logic [31:0] trk_bytes    = '0;
	logic [31:0] cnt_finished = '0;
	logic [31:0] cnt_whole    = '0;
	logic [31:0] cnt_bad      = '0;
	logic [31:0] cnt_late     = '0;

	report_t     pending_reports[$];
	int unsigned items_sent = 0;
	int unsigned failures   = 0;
	// When set, neither side of the stream inserts idle cycles.
	bit          no_gaps    = 1'b0;

	// Queues one result built from the current counters. Geometry of a
	// finished frame comes from the frame that the tracker holds right now.
	function automatic void post_report(input verdict_t v, input longint unsigned wo,
			input longint unsigned wl, input logic done, input logic whole,
			input logic last);
		report_t r;
		r.verdict      = v;
		r.wr_offset    = OFF_W'(wo);
		r.wr_length    = OFF_W'(wl);
		r.done         = done;
		r.done_w       = done ? DW_W'(trk_w) : '0;
		r.done_h       = done ? DH_W'(trk_h) : '0;
		r.done_whole   = done & whole;
		r.finished     = cnt_finished;
		r.whole_frames = cnt_whole;
		r.rejected     = cnt_bad;
		r.stragglers   = cnt_late;
		r.last         = last;
		pending_reports.push_back(r);
	endfunction

	// Closes the frame in progress and tells whether it got exactly its bytes.
	function automatic logic close_frame();
		longint unsigned full;
		logic            whole;
		full  = longint'(trk_w) * trk_h * PIX_BYTES;
		whole = (longint'(trk_bytes) == full);
		cnt_finished++;
		if (whole)
			cnt_whole++;
		return whole;
	endfunction

	// Advances the tracker copy by one accepted header and queues the results
	// that it must produce, in order.
	function automatic void track_header(input header_t c);
		longint unsigned n;
		longint unsigned full;
		longint unsigned off;
		logic [31:0]     diff;
		logic            whole;
		off = c.offset;
		if (c.length <= HDR_BYTES || c.magic != cfg_magic || c.version != cfg_version) begin
			cnt_bad++;
			post_report(VERDICT_BAD, 0, 0, 1'b0, 1'b0, 1'b1);
			return;
		end
		n    = c.length - HDR_BYTES;
		full = longint'(c.width) * c.height * PIX_BYTES;
		if (c.width == 0 || c.height == 0 || c.width[0] || c.width > MAXW || c.height > MAXH ||
				off > BUF_BYTES || n > BUF_BYTES - off || off + n > full) begin
			cnt_bad++;
			post_report(VERDICT_BAD, 0, 0, 1'b0, 1'b0, 1'b1);
			return;
		end
		// Wrap-safe age test: a negative difference means an older frame.
		diff = c.seq - trk_seq;
		if (trk_seen && (diff[31] || (c.seq == trk_seq && !trk_open))) begin
			cnt_late++;
			post_report(VERDICT_LATE, 0, 0, 1'b0, 1'b0, 1'b1);
			return;
		end
		if (c.seq != trk_seq || !trk_seen) begin
			// A newer frame first closes whatever is still open.
			if (trk_open) begin
				whole = close_frame();
				post_report(VERDICT_CLOSED, 0, 0, 1'b1, whole, 1'b0);
			end
			trk_seen  = 1'b1;
			trk_open  = 1'b1;
			trk_seq   = c.seq;
			trk_w     = c.width[8:0];
			trk_h     = c.height[7:0];
			trk_bytes = '0;
		end
		trk_bytes = trk_bytes + 32'(n);
		if (c.last) begin
			whole    = close_frame();
			trk_open = 1'b0;
			post_report(VERDICT_ACC, off, n, 1'b1, whole, 1'b1);
		end else begin
			post_report(VERDICT_ACC, off, n, 1'b0, 1'b0, 1'b1);
		end
	endfunction

	// A well-formed header for the current register settings.
	function automatic header_t make_chunk(input logic [31:0] seq, input int unsigned off,
			input int unsigned n, input logic [15:0] w, input logic [15:0] h,
			input logic last);
		header_t c;
		c.length  = 16'(n + HDR_BYTES);
		c.magic   = cfg_magic;
		c.version = cfg_version;
		c.last    = last;
		c.seq     = seq;
		c.offset  = off;
		c.width   = w;
		c.height  = h;
		return c;
	endfunction

	// Noise that lands between the chunks of a frame: random junk, runt
	// datagrams, chunks of older frames and broken headers.
	function automatic header_t stray_header(input logic [31:0] seq);
		header_t c;
		c = make_chunk(seq, 0, 4, 16'd2, 16'd1, 1'b0);
		case ($urandom_range(0, 4))
			0: begin
				c.length  = 16'($urandom);
				c.magic   = 16'($urandom);
				c.version = 8'($urandom);
				c.last    = 1'($urandom);
				c.seq     = $urandom;
				c.offset  = $urandom;
				c.width   = 16'($urandom);
				c.height  = 16'($urandom);
			end
			1: begin
				c.length = 16'($urandom);
				c.offset = $urandom;
				c.width  = 16'($urandom);
				c.height = 16'($urandom);
				c.last   = 1'($urandom);
			end
			2: c.length = 16'($urandom_range(0, HDR_BYTES));
			3: c = make_chunk(seq - $urandom_range(1, 1000), 0, $urandom_range(1, 4),
					16'd2, 16'd1, 1'($urandom));
			default: begin
				case ($urandom_range(0, 5))
					0: c.width   = 16'(2 * $urandom_range(0, 200) + 1);
					1: c.width   = 16'(2 * $urandom_range(MAXW / 2 + 1, 32767));
					2: c.height  = 16'($urandom_range(MAXH + 1, 65535));
					3: c.magic   = c.magic ^ 16'(1 << $urandom_range(0, 15));
					4: c.version = c.version ^ 8'(1 << $urandom_range(0, 7));
					default: c.offset = BUF_BYTES + $urandom_range(0, 100000);
				endcase
			end
		endcase
		return c;
	endfunction

	// Offers one header on the input stream after a random idle gap and
	// returns at the edge where the block takes it.
	task automatic send_header(input header_t c);
		int unsigned gap;
		gap = no_gaps ? 0 : $urandom_range(0, 5);
		@(negedge clk);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {c.height, c.width, c.offset, c.seq, c.version, c.magic, c.length};
		s_axis_tlast  <= c.last;
		do @(posedge clk); while (!s_axis_tready);
		track_header(c);
		items_sent++;
	endtask

	// Stops the input stream and waits until every queued result has come
	// out, then lets the pipeline settle.
	task automatic drain();
		@(negedge clk) s_axis_tvalid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes one register; the stream is idle whenever this runs.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_MAGIC)
			cfg_magic = value;
		else if (idx == REG_VERSION)
			cfg_version = value[7:0];
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	// Sends one frame as a run of chunks. Some frames lose a chunk, repeat
	// one, swap two, end without a last flag (the next sequence then closes
	// them) or close early, and noise may fall between the chunks.
	task automatic send_frame(input logic [31:0] seq, input bit full_size);
		logic [15:0] w;
		logic [15:0] h;
		int unsigned cap;
		int unsigned full;
		int unsigned pos;
		int unsigned n;
		int unsigned idx;
		int unsigned tmp;
		int unsigned offs[$];
		int unsigned lens[$];
		bit          closes;
		header_t     c;
		if (full_size) begin
			w   = 16'(MAXW);
			h   = 16'(MAXH);
			cap = 65535 - HDR_BYTES;
		end else begin
			w   = 16'(2 * $urandom_range(1, 12));
			h   = 16'($urandom_range(1, 8));
			cap = $urandom_range(1, 64);
		end
		full = w * h * PIX_BYTES;
		pos  = 0;
		while (pos < full) begin
			n = $urandom_range(1, (full - pos < cap) ? full - pos : cap);
			offs.push_back(pos);
			lens.push_back(n);
			pos += n;
		end
		if (offs.size() > 1 && $urandom_range(0, 5) == 0) begin
			idx = $urandom_range(0, offs.size() - 2);
			offs.delete(idx);
			lens.delete(idx);
		end
		if ($urandom_range(0, 7) == 0) begin
			idx = $urandom_range(0, offs.size() - 1);
			offs.insert(idx, offs[idx]);
			lens.insert(idx, lens[idx]);
		end
		if (offs.size() > 2 && $urandom_range(0, 5) == 0) begin
			idx           = $urandom_range(0, offs.size() - 3);
			tmp           = offs[idx];
			offs[idx]     = offs[idx + 1];
			offs[idx + 1] = tmp;
			tmp           = lens[idx];
			lens[idx]     = lens[idx + 1];
			lens[idx + 1] = tmp;
		end
		closes = ($urandom_range(0, 4) != 0);
		foreach (offs[i]) begin
			c = make_chunk(seq, offs[i], lens[i], w, h, closes && i == offs.size() - 1);
			if ($urandom_range(0, 11) == 0)
				c.last = 1'b1;
			// A chunk may claim other geometry than its frame.
			if ($urandom_range(0, 15) == 0) begin
				c.width  = 16'(2 * $urandom_range(1, MAXW / 2));
				c.height = 16'($urandom_range(1, MAXH));
			end
			if ($urandom_range(0, 9) == 0)
				send_header(stray_header(seq));
			send_header(c);
		end
	endtask

	// Every header check on its own, before any frame exists.
	task automatic test_header_checks();
		header_t c;
		write_reg(REG_MAGIC, 16'hA5C3);
		write_reg(REG_VERSION, 16'h005A);
		c = make_chunk(32'd5, 0, 4, 16'd2, 16'd1, 1'b0);
		c.length = 16'(HDR_BYTES);          // header only, no payload
		send_header(c);
		c.length = 16'd0;
		send_header(c);
		c = make_chunk(32'd5, 0, 4, 16'd2, 16'd1, 1'b0);
		c.magic = cfg_magic ^ 16'h8000;
		send_header(c);
		c = make_chunk(32'd5, 0, 4, 16'd2, 16'd1, 1'b0);
		c.version = cfg_version ^ 8'h01;
		send_header(c);
		send_header(make_chunk(32'd5, 0, 4, 16'd0, 16'd1, 1'b0));       // zero width
		send_header(make_chunk(32'd5, 0, 4, 16'd3, 16'd1, 1'b0));       // odd width
		send_header(make_chunk(32'd5, 0, 4, 16'(MAXW + 2), 16'd1, 1'b0));
		send_header(make_chunk(32'd5, 0, 4, 16'hFFFF, 16'd1, 1'b0));
		send_header(make_chunk(32'd5, 0, 4, 16'd2, 16'd0, 1'b0));       // zero height
		send_header(make_chunk(32'd5, 0, 4, 16'd2, 16'(MAXH + 1), 1'b0));
		send_header(make_chunk(32'd5, 0, 4, 16'd2, 16'hFFFF, 1'b0));
		// Offsets past the staging buffer, and a payload running over its end.
		send_header(make_chunk(32'd5, BUF_BYTES + 1, 1, 16'(MAXW), 16'(MAXH), 1'b0));
		send_header(make_chunk(32'd5, 32'hFFFF_FFFF, 1, 16'(MAXW), 16'(MAXH), 1'b0));
		send_header(make_chunk(32'd5, BUF_BYTES - 10, 11, 16'(MAXW), 16'(MAXH), 1'b0));
		// Payload longer than the frame itself.
		send_header(make_chunk(32'd5, 0, 5, 16'd2, 16'd1, 1'b0));
		drain();
	endtask

	// Frame open, close by last flag, close by newer sequence, and late
	// chunks on both sides of the sequence wrap.
	task automatic test_frame_lifecycle();
		// Largest payload, ending exactly at the end of the buffer.
		send_header(make_chunk(32'hFFFF_FFFF, BUF_BYTES - 65519, 65519, 16'(MAXW),
			16'(MAXH), 1'b0));
		send_header(make_chunk(32'hFFFF_FFFF, 0, 100, 16'(MAXW), 16'(MAXH), 1'b1));
		// Same sequence after its frame closed.
		send_header(make_chunk(32'hFFFF_FFFF, 0, 4, 16'd2, 16'd1, 1'b0));
		// Sequence wraps to zero: newer, and nothing is open to close.
		send_header(make_chunk(32'd0, 0, 4, 16'd2, 16'd1, 1'b0));
		// Newer sequence while a whole frame is open gives two results.
		send_header(make_chunk(32'd1, 0, 16, 16'd4, 16'd2, 1'b0));
		send_header(make_chunk(32'd0, 0, 4, 16'd2, 16'd1, 1'b0));
		// Exactly half the sequence space ahead counts as older.
		send_header(make_chunk(32'h8000_0001, 0, 4, 16'd2, 16'd1, 1'b0));
		send_header(make_chunk(32'h8000_0000, 0, 8, 16'd2, 16'd2, 1'b1));
		drain();
	endtask

	// Random frame traffic under one register setting. A steady phase runs
	// without idle cycles on either side.
	task automatic test_reassembly_traffic(input logic [15:0] magic, input logic [7:0] version,
			input int unsigned count, input bit steady);
		int unsigned stop_at;
		int unsigned next_pause;
		int unsigned roll;
		logic [31:0] seq;
		write_reg(REG_MAGIC, magic);
		// The upper byte of a version write carries nothing.
		write_reg(REG_VERSION, {8'($urandom), version});
		no_gaps    = steady;
		stop_at    = items_sent + count;
		next_pause = items_sent + $urandom_range(60, 150);
		seq        = trk_seen ? trk_seq + 1 : $urandom;
		while (items_sent < stop_at) begin
			roll = $urandom_range(0, 19);
			if (roll == 0) begin
				// A straggling frame from a few sequences back.
				send_frame(seq - $urandom_range(1, 4), 1'b0);
			end else begin
				send_frame(seq, roll == 1);
				seq += (roll == 2) ? $urandom_range(2, 32'h7FFF_FFFF) : $urandom_range(1, 2);
			end
			if (!steady && $urandom_range(0, 9) == 0)
				no_gaps = !no_gaps;
			// Now and then hold the input until the output has caught up.
			if (items_sent >= next_pause) begin
				drain();
				next_pause = items_sent + $urandom_range(60, 150);
			end
		end
		no_gaps = 1'b0;
		drain();
	endtask

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			failures++;
			$display("%0t ns: %s expected %0d got %0d", $time, what, want, got);
		end
	endtask

	// Result sink: draws a random stall before each result it takes.
	initial begin : result_sink
		int unsigned stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 5);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			@(negedge clk);
		end
	end

	// Every result transaction is compared with the oldest queued result.
	always @(posedge clk) begin : result_check
		report_t          want;
		logic [RES_W-1:0] d;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			d = m_axis_tdata;
			if (pending_reports.size() == 0) begin
				failures++;
				$display("%0t ns: result expected none got verdict %0d", $time,
					m_axis_tuser);
			end else begin
				want = pending_reports.pop_front();
				check_field("verdict", 32'(want.verdict), 32'(m_axis_tuser));
				check_field("write_offset", 32'(want.wr_offset), 32'(d[0 +: OFF_W]));
				check_field("write_length", 32'(want.wr_length), 32'(d[P_WLEN +: OFF_W]));
				check_field("frame_done", 32'(want.done), 32'(d[P_DONE]));
				check_field("done_width", 32'(want.done_w), 32'(d[P_DW +: DW_W]));
				check_field("done_height", 32'(want.done_h), 32'(d[P_DH +: DH_W]));
				check_field("done_whole", 32'(want.done_whole), 32'(d[P_WHOLE]));
				check_field("frames_finished", want.finished, d[P_FIN +: 32]);
				check_field("frames_whole", want.whole_frames, d[P_WHC +: 32]);
				check_field("bad_count", want.rejected, d[P_BAD +: 32]);
				check_field("late_count", want.stragglers, d[P_LATE +: 32]);
				check_field("last_result", 32'(want.last), 32'(m_axis_tlast));
			end
		end
	end

	// Watchdog far beyond the slowest legal run.
	initial begin
		#(5_000_000);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_MAGIC;
		cfg_data      = '0;
		arst_n        = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		test_header_checks();
		test_frame_lifecycle();
		test_reassembly_traffic(16'h0000, 8'h00, 276, 1'b0);
		test_reassembly_traffic(16'hFFFF, 8'hFF, 276, 1'b0);
		test_reassembly_traffic(16'($urandom), 8'($urandom), 276, 1'b0);
		test_reassembly_traffic(16'($urandom), 8'($urandom), 276, 1'b1);
		test_reassembly_traffic(16'($urandom), 8'($urandom), 276, 1'b0);

		repeat (10) @(posedge clk);
		if (failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
